// ===== src/msva_pkg.sv =====
// Shared types and constants of the MIDI string voice allocator.
package msva_pkg;

  localparam logic [7:0] KIND_MASK = 8'hF0;
  localparam logic [7:0] KIND_OFF  = 8'h80;
  localparam logic [7:0] KIND_ON   = 8'h90;
  localparam logic [7:0] KIND_CC   = 8'hB0;

  localparam logic [1:0] ITEM_NOTE_ON  = 2'd0;
  localparam logic [1:0] ITEM_NOTE_OFF = 2'd1;
  localparam logic [1:0] ITEM_STATUS   = 2'd2;

  localparam int PACKED_STRINGS = 8;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_COUNT  = 3'd1;
  localparam logic [2:0] REG_ENABLE = 3'd2;
  localparam logic [2:0] REG_OPEN   = 3'd3;
  localparam logic [2:0] REG_ZLOW   = 3'd4;
  localparam logic [2:0] REG_ZHIGH  = 3'd5;
  localparam logic [2:0] REG_THRESH = 3'd6;
  localparam logic [2:0] REG_SPAN   = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OWNER,
    ST_PICK,
    ST_EMIT_ON,
    ST_RELEASE,
    ST_STATUS
  } state_t;

  // Result of the per-string compare unit for one scanned string.
  typedef struct packed {
    logic addressable;
    logic match;
    logic playable;
    logic [7:0] fret;
  } str_eval_t;

endpackage

// ===== src/msva_string_eval.sv =====
// Compare unit shared by all scan steps: evaluates one string per cycle.
module msva_string_eval (
  input  logic [3:0]  idx,
  input  logic [3:0]  eff_count,
  input  logic        mode,
  input  logic [7:0]  enable_mask,
  input  logic [55:0] open_notes,
  input  logic [55:0] zone_low,
  input  logic [55:0] zone_high,
  input  logic [6:0]  fret_span,
  input  logic [6:0]  note,
  input  logic [3:0]  ch,
  input  logic        owned,
  input  logic [3:0]  own_ch,
  input  logic [6:0]  own_note,
  output msva_pkg::str_eval_t res
);
  import msva_pkg::*;

  logic       in_pack;
  logic [2:0] sel;
  logic [6:0] open_n, lo_n, hi_n;
  logic [7:0] top;
  logic       en;

  always_comb begin
    in_pack = (idx < 4'(PACKED_STRINGS));
    sel     = idx[2:0];
    open_n  = in_pack ? open_notes[7*sel +: 7] : 7'd0;
    lo_n    = in_pack ? zone_low[7*sel +: 7]   : 7'd0;
    hi_n    = in_pack ? zone_high[7*sel +: 7]  : 7'd0;
    en      = in_pack && enable_mask[sel];
    top     = {1'b0, open_n} + {1'b0, fret_span};
    res.addressable = en && (idx < eff_count);
    res.match       = owned && (own_ch == ch) && (own_note == note);
    if (!mode) begin
      res.playable = (note >= open_n) && ({1'b0, note} <= top);
      res.fret     = {1'b0, note} - {1'b0, open_n};
    end else begin
      res.playable = (note >= lo_n) && (note <= hi_n);
      res.fret     = 8'd0;
    end
  end
endmodule

// ===== src/midi_string_voice_allocator.sv =====
// Top level of the MIDI string voice allocator: registers, state and scan sequencer.
//
// One MIDI event is taken when start is high and busy low; busy then stays high
// while a small sequencer walks the strings one per cycle through a single compare
// unit. After a note-on busy stays high through the owner scan, candidate scan and
// emit; after a note-off or a pedal-up release through one string scan; after other
// events not at all. An end-of-block status item adds the status step to any of
// these. Each result shows up the cycle after the scan step that makes it.
// Results appear on out_* for one cycle each, marked by out_valid, with out_last
// on the final one of an event; the receiver cannot stall them. Up to NUM_STRINGS+1
// results per event. Configuration goes through the APB-style port at byte address
// 8*i; the user must write it only while idle, as the block does not enforce that.
module midi_string_voice_allocator #(
  parameter int NUM_STRINGS        = 8,
  parameter int SUSTAIN_CONTROLLER = 64,
  parameter int MIN_NOTE           = 21,
  parameter int MAX_NOTE           = 108
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_status,
  input  logic [3:0]  in_midi_channel,
  input  logic [6:0]  in_data_one,
  input  logic [6:0]  in_data_two,
  input  logic [30:0] in_sample_offset,
  input  logic        in_end_of_block,
  output logic        out_valid,
  output logic [1:0]  out_item_kind,
  output logic [2:0]  out_string_index,
  output logic [3:0]  out_channel,
  output logic [6:0]  out_note,
  output logic [6:0]  out_velocity,
  output logic [30:0] out_offset,
  output logic        out_sustain_down,
  output logic [31:0] out_out_of_range_count,
  output logic [31:0] out_unassignable_count,
  output logic [31:0] out_lost_note_off_count,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import msva_pkg::*;

  localparam int SW = (NUM_STRINGS > 1) ? $clog2(NUM_STRINGS) : 1;

  // configuration
  logic        mode_r;
  logic [3:0]  count_r;
  logic [7:0]  enable_r;
  logic [55:0] open_r, zlow_r, zhigh_r;
  logic [6:0]  thresh_r, span_r;

  // per-string state
  logic [NUM_STRINGS-1:0] owned_r, held_r;
  logic [3:0]  own_ch_r  [NUM_STRINGS];
  logic [6:0]  own_note_r[NUM_STRINGS];
  logic [6:0]  rel_vel_r [NUM_STRINGS];
  logic [63:0] trig_r    [NUM_STRINGS];
  logic [63:0] trig_cnt_r;
  logic        pedal_r;
  logic [31:0] range_tot_r, unas_tot_r, lost_tot_r;

  // item latch and sequencer
  state_t      state_r, state_nxt;
  logic [SW-1:0] idx_r;
  logic [3:0]  ch_r;
  logic [6:0]  note_r, vel_r;
  logic [30:0] off_r;
  logic        eob_r;
  logic        found_r, found_addr_r;
  logic [SW-1:0] found_idx_r;
  logic        idle_v_r, steal_v_r;
  logic [SW-1:0] idle_s_r, steal_s_r;
  logic [7:0]  idle_fret_r;
  logic [63:0] idle_seq_r, steal_seq_r;

  logic [3:0]  eff_count;
  logic [NUM_STRINGS-1:0] addr_mask;
  str_eval_t   ev;
  logic        last_idx;
  logic        cfg_wr;
  logic [2:0]  cfg_sel;

  always_comb begin
    if (count_r == 4'd0) eff_count = 4'd1;
    else if (32'(count_r) > NUM_STRINGS) eff_count = 4'(NUM_STRINGS);
    else eff_count = count_r;
  end

  // strings that can still be addressed; decides which release is the last one
  always_comb begin
    for (int i = 0; i < NUM_STRINGS; i++)
      addr_mask[i] = (i < PACKED_STRINGS) && (i < int'(eff_count)) && enable_r[3'(i)];
  end

  msva_string_eval u_eval (
    .idx        (4'(idx_r)),
    .eff_count  (eff_count),
    .mode       (mode_r),
    .enable_mask(enable_r),
    .open_notes (open_r),
    .zone_low   (zlow_r),
    .zone_high  (zhigh_r),
    .fret_span  (span_r),
    .note       (note_r),
    .ch         (ch_r),
    .owned      (owned_r[idx_r]),
    .own_ch     (own_ch_r[idx_r]),
    .own_note   (own_note_r[idx_r]),
    .res        (ev)
  );

  assign last_idx = (32'(idx_r) == NUM_STRINGS - 1);
  assign busy     = (state_r != ST_IDLE);
  assign pready   = 1'b1;
  assign cfg_sel  = paddr[5:3];
  assign cfg_wr   = psel && penable && pwrite && pready;

  // APB read mux
  always_comb begin
    prdata = '0;
    unique case (cfg_sel)
      REG_MODE:   prdata = 64'(mode_r);
      REG_COUNT:  prdata = 64'(count_r);
      REG_ENABLE: prdata = 64'(enable_r);
      REG_OPEN:   prdata = 64'(open_r);
      REG_ZLOW:   prdata = 64'(zlow_r);
      REG_ZHIGH:  prdata = 64'(zhigh_r);
      REG_THRESH: prdata = 64'(thresh_r);
      REG_SPAN:   prdata = 64'(span_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0; count_r <= 4'd6; enable_r <= 8'hFF;
      open_r <= '0; zlow_r <= '0; zhigh_r <= '0;
      thresh_r <= 7'd64; span_r <= 7'd24;
    end else if (cfg_wr && paddr[2:0] == 3'd0) begin
      unique case (cfg_sel)
        REG_MODE:   mode_r   <= pwdata[0];
        REG_COUNT:  count_r  <= pwdata[3:0];
        REG_ENABLE: enable_r <= pwdata[7:0];
        REG_OPEN:   open_r   <= pwdata[55:0];
        REG_ZLOW:   zlow_r   <= pwdata[55:0];
        REG_ZHIGH:  zhigh_r  <= pwdata[55:0];
        REG_THRESH: thresh_r <= pwdata[6:0];
        REG_SPAN:   span_r   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // decoded event, used on the accept edge
  logic [7:0] kind_in;
  logic       is_cc_pedal, pedal_new, is_on, is_off, in_range;
  always_comb begin
    kind_in     = in_status & KIND_MASK;
    is_cc_pedal = (kind_in == KIND_CC) && (32'(in_data_one) == SUSTAIN_CONTROLLER);
    pedal_new   = (in_data_two >= thresh_r);
    is_on       = (kind_in == KIND_ON) && (in_data_two != 7'd0);
    is_off      = (kind_in == KIND_OFF) || ((kind_in == KIND_ON) && (in_data_two == 7'd0));
    in_range    = (32'(in_data_one) >= MIN_NOTE) && (32'(in_data_one) <= MAX_NOTE);
  end

  // Sequencer mode latched at accept: 1 owner scan for note-on, 0 note-off
  logic on_mode_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          priority if (is_cc_pedal && pedal_new != pedal_r && !pedal_new) state_nxt = ST_RELEASE;
          else if (is_on && in_range) state_nxt = ST_OWNER;
          else if (is_off) state_nxt = ST_OWNER;
          else if (in_end_of_block) state_nxt = ST_STATUS;
          else state_nxt = ST_IDLE;
        end
      end
      ST_OWNER: begin
        if (last_idx) begin
          if (on_mode_r) state_nxt = ST_PICK;
          else state_nxt = eob_r ? ST_STATUS : ST_IDLE;
        end
      end
      ST_PICK:    if (last_idx) state_nxt = ST_EMIT_ON;
      ST_EMIT_ON: state_nxt = eob_r ? ST_STATUS : ST_IDLE;
      ST_RELEASE: if (last_idx) state_nxt = eob_r ? ST_STATUS : ST_IDLE;
      ST_STATUS:  state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // owner found in the scan so far (including the current string)
  logic          own_hit;
  logic [SW-1:0] own_idx;
  logic          own_addr;
  always_comb begin
    own_hit  = found_r || ev.match;
    own_idx  = found_r ? found_idx_r : idx_r;
    own_addr = found_r ? found_addr_r : ev.addressable;
  end

  // candidate choice for the pick scan
  logic cand, take_idle, take_steal;
  always_comb begin
    cand       = ev.addressable && ev.playable;
    take_idle  = cand && !owned_r[idx_r] &&
                 (!idle_v_r || ev.fret < idle_fret_r ||
                  (ev.fret == idle_fret_r && trig_r[idx_r] < idle_seq_r));
    take_steal = cand && owned_r[idx_r] && (!steal_v_r || trig_r[idx_r] < steal_seq_r);
  end

  // outputs and datapath
  logic          emit_v, emit_last;
  logic [1:0]    emit_kind;
  logic [SW-1:0] emit_s;
  logic [3:0]    emit_ch;
  logic [6:0]    emit_note, emit_vel;
  logic          pick_ok;
  logic [SW-1:0] pick_s;
  logic          off_emit;
  always_comb begin
    emit_v = 1'b0; emit_last = 1'b0; emit_kind = ITEM_NOTE_ON;
    emit_s = '0; emit_ch = '0; emit_note = '0; emit_vel = '0;
    pick_ok = found_r && found_addr_r || idle_v_r || steal_v_r;
    pick_s  = (found_r && found_addr_r) ? found_idx_r : (idle_v_r ? idle_s_r : steal_s_r);
    off_emit = !on_mode_r && last_idx && own_hit && own_addr && !pedal_r;
    unique case (state_r)
      ST_OWNER: if (off_emit) begin
        emit_v = 1'b1; emit_kind = ITEM_NOTE_OFF; emit_s = own_idx;
        emit_ch = ch_r; emit_note = note_r; emit_vel = vel_r; emit_last = !eob_r;
      end
      ST_EMIT_ON: if (pick_ok) begin
        emit_v = 1'b1; emit_kind = ITEM_NOTE_ON; emit_s = pick_s;
        emit_ch = ch_r; emit_note = note_r; emit_vel = vel_r; emit_last = !eob_r;
      end
      ST_RELEASE: if (owned_r[idx_r] && held_r[idx_r] && ev.addressable) begin
        // last only when no addressable held string remains further up
        emit_v = 1'b1; emit_kind = ITEM_NOTE_OFF; emit_s = idx_r;
        emit_ch = own_ch_r[idx_r]; emit_note = own_note_r[idx_r];
        emit_vel = rel_vel_r[idx_r];
        emit_last = !eob_r &&
                    ((owned_r & held_r & addr_mask) >> idx_r) == NUM_STRINGS'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; idx_r <= '0; owned_r <= '0; held_r <= '0;
      trig_cnt_r <= '0; pedal_r <= 1'b0;
      range_tot_r <= '0; unas_tot_r <= '0; lost_tot_r <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_STRINGS; i++) begin
        own_ch_r[i] <= '0; own_note_r[i] <= '0; rel_vel_r[i] <= '0; trig_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      if (state_nxt != state_r) idx_r <= '0;
      else if (state_r != ST_IDLE) idx_r <= idx_r + SW'(1);
      unique case (state_r)
        ST_IDLE: if (start) begin
          ch_r <= in_midi_channel; note_r <= in_data_one; vel_r <= in_data_two;
          off_r <= in_sample_offset; eob_r <= in_end_of_block;
          on_mode_r <= is_on; found_r <= 1'b0;
          idle_v_r <= 1'b0; steal_v_r <= 1'b0;
          if (is_cc_pedal && pedal_new != pedal_r) pedal_r <= pedal_new;
          if (is_on && !in_range) range_tot_r <= range_tot_r + 32'd1;
        end
        ST_OWNER: begin
          if (ev.match && !found_r) begin
            found_r <= 1'b1; found_idx_r <= idx_r; found_addr_r <= ev.addressable;
          end
          if (on_mode_r && ev.match && !found_r && !ev.addressable) begin
            // stale owner of an unaddressable string: drop it now
            if (held_r[idx_r]) lost_tot_r <= lost_tot_r + 32'd1;
            owned_r[idx_r] <= 1'b0; held_r[idx_r] <= 1'b0;
          end
          if (!on_mode_r && last_idx && own_hit) begin
            if (!own_addr) begin
              lost_tot_r <= lost_tot_r + 32'd1;
              owned_r[own_idx] <= 1'b0; held_r[own_idx] <= 1'b0;
            end else if (pedal_r) begin
              held_r[own_idx] <= 1'b1; rel_vel_r[own_idx] <= vel_r;
            end else begin
              rel_vel_r[own_idx] <= vel_r;
              owned_r[own_idx] <= 1'b0; held_r[own_idx] <= 1'b0;
            end
          end
        end
        ST_PICK: begin
          if (take_idle) begin
            idle_v_r <= 1'b1; idle_s_r <= idx_r;
            idle_fret_r <= ev.fret; idle_seq_r <= trig_r[idx_r];
          end
          if (take_steal) begin
            steal_v_r <= 1'b1; steal_s_r <= idx_r; steal_seq_r <= trig_r[idx_r];
          end
        end
        ST_EMIT_ON: begin
          if (pick_ok) begin
            owned_r[pick_s] <= 1'b1; own_ch_r[pick_s] <= ch_r;
            own_note_r[pick_s] <= note_r; held_r[pick_s] <= 1'b0;
            rel_vel_r[pick_s] <= 7'd0; trig_r[pick_s] <= trig_cnt_r + 64'd1;
            trig_cnt_r <= trig_cnt_r + 64'd1;
          end else unas_tot_r <= unas_tot_r + 32'd1;
        end
        ST_RELEASE: begin
          if (owned_r[idx_r] && held_r[idx_r]) begin
            if (!ev.addressable) lost_tot_r <= lost_tot_r + 32'd1;
            owned_r[idx_r] <= 1'b0; held_r[idx_r] <= 1'b0;
          end
        end
        default: ;
      endcase
      if (emit_v) begin
        out_valid <= 1'b1; out_item_kind <= emit_kind;
        out_string_index <= 3'(emit_s); out_channel <= emit_ch;
        out_note <= emit_note; out_velocity <= emit_vel; out_offset <= off_r;
        out_sustain_down <= 1'b0; out_out_of_range_count <= '0;
        out_unassignable_count <= '0; out_lost_note_off_count <= '0;
        out_last <= emit_last;
      end
      if (state_r == ST_STATUS) begin
        out_valid <= 1'b1; out_item_kind <= ITEM_STATUS;
        out_string_index <= '0; out_channel <= '0; out_note <= '0;
        out_velocity <= '0; out_offset <= off_r; out_sustain_down <= pedal_r;
        out_out_of_range_count <= range_tot_r; out_unassignable_count <= unas_tot_r;
        out_lost_note_off_count <= lost_tot_r; out_last <= 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_start_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> busy) else $error("busy low outside idle");
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item_kind == ITEM_STATUS) |-> out_last)
    else $error("status item not last");
  a_held_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r & ~owned_r) == '0) else $error("held string not owned");
  a_trig_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r) == ST_EMIT_ON && rst_n && $past(rst_n) |->
    trig_cnt_r >= $past(trig_cnt_r)) else $error("trigger counter went back");
`endif
endmodule
